/* design/rat_pkg.sv */
package rat_pkg;

    // Event codes carried in the func field of an input item.
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_ACK   = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // Transmit state of one route.
    typedef logic [1:0] t_rstate;
    localparam t_rstate ST_IDLE        = 2'd0;
    localparam t_rstate ST_FRESH       = 2'd1;
    localparam t_rstate ST_AWAIT       = 2'd2;
    localparam t_rstate ST_AWAIT_FRESH = 2'd3;

    // Configuration register indexes and port widths.
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 32;
    localparam logic [CFG_IW-1:0] CFG_NUM_ROUTES = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_ACKED_MASK = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_TIMEOUT    = 2'd2;
    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

    // Transmissions announced per tick, and the widths that follow from it.
    localparam int MAX_RES = 8;
    localparam int RES_IW  = $clog2(MAX_RES);
    localparam int RES_CW  = $clog2(MAX_RES + 1);

    // One input item.
    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  ack_id;
        logic [31:0] now;
        logic [3:0]  free_slots;
    } t_in;

    // One result item.
    typedef struct packed {
        logic       sent;
        logic [2:0] route;
        logic       acked;
        logic [7:0] tx_ack_id;
        logic       all_clear;
        logic       last;
    } t_out;

    // One route entry as held in the route memory.
    typedef struct packed {
        t_rstate     state;
        logic [7:0]  ack_id;
        logic [31:0] tx_time;
    } t_entry;

    // One buffered transmission of the current tick.
    typedef struct packed {
        logic [2:0] route;
        logic       acked;
        logic [7:0] tx_ack_id;
    } t_res;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic issue;
        logic take;
    } t_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_done;
        logic out_last;
    } t_sts;

endpackage

/* design/rat_ram.sv */
module rat_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/rat_ctrl.sv */
module rat_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_stall,
    input  rat_pkg::t_sts i_sts,
    output rat_pkg::t_ctl o_ctl,
    output logic          o_in_stall,
    output logic          o_out_valid
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic          r_in_stall;
    logic          r_out_valid;
    rat_pkg::t_ctl n_ctl;

    // Next state and the commands for this cycle.
    always_comb begin
        n_state = r_state;
        n_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_ctl.start = 1'b1;
                    n_state     = S_WALK;
                end
            end
            S_WALK: begin
                n_ctl.issue = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_out_stall) begin
                    n_ctl.take = 1'b1;
                    if (i_sts.out_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and the registered handshake outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_stall  <= (n_state != S_IDLE);
            r_out_valid <= (n_state == S_DRAIN);
        end
    end

    assign o_ctl       = n_ctl;
    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

endmodule

/* design/rat_dpath.sv */
module rat_dpath #(
    parameter int ROUTES = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rat_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  logic [rat_pkg::CFG_DW-1:0]  i_cfg_data,
    input  rat_pkg::t_in                i_in,
    input  rat_pkg::t_ctl               i_ctl,
    output rat_pkg::t_sts               o_sts,
    output rat_pkg::t_out               o_out
);

    localparam int RW = (ROUTES > 1) ? $clog2(ROUTES) : 1;
    localparam int NW = $clog2(ROUTES + 1);
    localparam int EW = $bits(rat_pkg::t_entry);

    // Configuration registers.
    logic [3:0]  r_num_routes;
    logic [7:0]  r_acked_mask;
    logic [31:0] r_timeout;

    // The item being worked on.
    logic [1:0]                 r_func;
    logic [7:0]                 r_aid;
    logic [31:0]                r_now;
    logic [rat_pkg::RES_CW-1:0] r_slots;

    // Walk over the routes: read issue and process stage.
    logic [RW-1:0]     r_addr;
    logic [NW-1:0]     r_left;
    logic              r_pv;
    logic [RW-1:0]     r_pr;
    logic [ROUTES-1:0] r_vld;
    logic [7:0]        r_next_id;
    logic [RW-1:0]     r_last_srv;

    // Results of the item.
    logic                       r_clear;
    logic [rat_pkg::RES_CW-1:0] r_cnt;
    logic [rat_pkg::RES_IW-1:0] r_rd;
    rat_pkg::t_res              r_buf [rat_pkg::MAX_RES];

    logic [NW-1:0]              w_n;
    logic [RW-1:0]              w_start;
    logic [RW-1:0]              w_addr_nx;
    logic [ROUTES-1:0]          w_mask;
    logic [EW-1:0]              w_q_bits;
    rat_pkg::t_entry            w_q;
    rat_pkg::t_entry            w_ent_nx;
    rat_pkg::t_rstate           w_st;
    logic [31:0]                w_elapsed;
    logic                       w_ak;
    logic                       w_send;
    logic                       w_we;
    logic [rat_pkg::RES_CW-1:0] w_slots_cap;

    // Routes in use, capped at the number of routes built.
    always_comb begin
        if (int'(r_num_routes) > ROUTES) begin
            w_n = NW'(ROUTES);
        end else begin
            w_n = NW'(r_num_routes);
        end
    end

    // The walk starts just after the last route served, wrapping to route 0.
    always_comb begin
        if (int'(r_last_srv) + 1 >= int'(w_n)) begin
            w_start = '0;
        end else begin
            w_start = RW'(int'(r_last_srv) + 1);
        end
        if (int'(r_addr) + 1 >= int'(w_n)) begin
            w_addr_nx = '0;
        end else begin
            w_addr_nx = RW'(int'(r_addr) + 1);
        end
    end

    assign w_slots_cap = (int'(i_in.free_slots) > rat_pkg::MAX_RES) ?
                         rat_pkg::RES_CW'(rat_pkg::MAX_RES) :
                         rat_pkg::RES_CW'(i_in.free_slots);

    // Only the first eight routes can be acked.
    for (genvar g = 0; g < ROUTES; g++) begin : g_mask
        if (g < 8) begin : g_in
            assign w_mask[g] = r_acked_mask[g];
        end else begin : g_out
            assign w_mask[g] = 1'b0;
        end
    end

    // Route memory: state, ack id and transmit time of each route.
    rat_ram #(
        .WIDTH (EW),
        .DEPTH (ROUTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_pr),
        .i_wdata (w_ent_nx),
        .i_raddr (r_addr),
        .o_rdata (w_q_bits)
    );

    assign w_q       = rat_pkg::t_entry'(w_q_bits);
    assign w_st      = r_vld[r_pr] ? w_q.state : rat_pkg::ST_IDLE;
    assign w_ak      = w_mask[r_pr];
    assign w_elapsed = r_now - w_q.tx_time;
    assign w_we      = r_pv && ((r_func == rat_pkg::FUNC_WRITE) ||
                                (r_func == rat_pkg::FUNC_ACK) ||
                                (r_func == rat_pkg::FUNC_TICK));

    // New entry of the route in the process stage.
    always_comb begin
        w_ent_nx       = w_q;
        w_ent_nx.state = w_st;
        w_send         = 1'b0;
        case (r_func)
            rat_pkg::FUNC_WRITE: begin
                w_ent_nx.state = (w_st == rat_pkg::ST_AWAIT) ?
                                 rat_pkg::ST_AWAIT_FRESH : rat_pkg::ST_FRESH;
            end
            rat_pkg::FUNC_ACK: begin
                if (w_q.ack_id == r_aid) begin
                    if (w_st == rat_pkg::ST_AWAIT) begin
                        w_ent_nx.state = rat_pkg::ST_IDLE;
                    end else if (w_st == rat_pkg::ST_AWAIT_FRESH) begin
                        w_ent_nx.state = rat_pkg::ST_FRESH;
                    end
                end
            end
            rat_pkg::FUNC_TICK: begin
                if (w_st == rat_pkg::ST_FRESH) begin
                    if (r_slots != '0) begin
                        w_send           = 1'b1;
                        w_ent_nx.tx_time = r_now;
                        if (w_ak) begin
                            w_ent_nx.state  = rat_pkg::ST_AWAIT;
                            w_ent_nx.ack_id = r_next_id;
                        end else begin
                            w_ent_nx.state  = rat_pkg::ST_IDLE;
                        end
                    end
                end else if (((w_st == rat_pkg::ST_AWAIT) ||
                              (w_st == rat_pkg::ST_AWAIT_FRESH)) &&
                             (w_elapsed > r_timeout)) begin
                    // An abandoned wait drops its awaiting mark.
                    w_ent_nx.state = (w_st == rat_pkg::ST_AWAIT) ?
                                     rat_pkg::ST_IDLE : rat_pkg::ST_FRESH;
                end
            end
            default: begin
            end
        endcase
    end

    // Control state: configuration, walk counters, route valid bits, results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_routes <= '0;
            r_acked_mask <= '0;
            r_timeout    <= rat_pkg::TIMEOUT_RESET;
            r_left       <= '0;
            r_pv         <= 1'b0;
            r_vld        <= '0;
            r_next_id    <= '0;
            r_last_srv   <= '0;
            r_slots      <= '0;
            r_clear      <= 1'b1;
            r_cnt        <= '0;
            r_rd         <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rat_pkg::CFG_NUM_ROUTES: r_num_routes <= i_cfg_data[3:0];
                    rat_pkg::CFG_ACKED_MASK: r_acked_mask <= i_cfg_data[7:0];
                    rat_pkg::CFG_TIMEOUT:    r_timeout    <= i_cfg_data[31:0];
                    default: begin
                    end
                endcase
            end
            if (i_ctl.start) begin
                r_left  <= w_n;
                r_pv    <= 1'b0;
                r_slots <= w_slots_cap;
                r_clear <= 1'b1;
                r_cnt   <= '0;
                r_rd    <= '0;
            end
            if (i_ctl.issue) begin
                if (r_left != '0) begin
                    r_pv   <= 1'b1;
                    r_left <= r_left - NW'(1);
                end else begin
                    r_pv   <= 1'b0;
                end
            end
            if (r_pv) begin
                if (w_we) begin
                    r_vld[r_pr] <= 1'b1;
                end
                r_clear <= r_clear && (w_ent_nx.state == rat_pkg::ST_IDLE);
                if (w_send) begin
                    r_slots    <= r_slots - rat_pkg::RES_CW'(1);
                    r_cnt      <= r_cnt + rat_pkg::RES_CW'(1);
                    r_last_srv <= r_pr;
                    if (w_ak) begin
                        r_next_id <= r_next_id + 8'd1;
                    end
                end
            end
            if (i_ctl.take) begin
                r_rd <= r_rd + rat_pkg::RES_IW'(1);
            end
        end
    end

    // Item fields, walk addresses and the transmission buffer.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_func <= i_in.func;
            r_aid  <= i_in.ack_id;
            r_now  <= i_in.now;
            r_addr <= w_start;
        end
        if (i_ctl.issue && (r_left != '0)) begin
            r_pr   <= r_addr;
            r_addr <= w_addr_nx;
        end
        if (r_pv && w_send) begin
            r_buf[r_cnt[rat_pkg::RES_IW-1:0]] <= '{
                route:     3'(r_pr),
                acked:     w_ak,
                tx_ack_id: w_ak ? r_next_id : 8'd0
            };
        end
    end

    // Status back to the controller.
    assign o_sts.walk_done = (r_left == '0);
    assign o_sts.out_last  = (rat_pkg::RES_CW'(r_rd) + rat_pkg::RES_CW'(1) >= r_cnt);

    // Result item: a buffered transmission, or a single empty result.
    always_comb begin
        o_out           = '0;
        o_out.all_clear = r_clear;
        o_out.last      = o_sts.out_last;
        if (r_cnt != '0) begin
            o_out.sent      = 1'b1;
            o_out.route     = r_buf[r_rd].route;
            o_out.acked     = r_buf[r_rd].acked;
            o_out.tx_ack_id = r_buf[r_rd].tx_ack_id;
        end
    end

endmodule

/* design/route_ack_tracker.sv */
// Transmit-state tracker for up to ROUTES routes.
// Input channel (i_in_valid, o_in_stall, i_in) carries events: new data
// written, ack received, or service tick. Output channel (o_out_valid,
// i_out_stall, o_out) returns one result per transmission of a tick, or a
// single empty result when nothing is sent; o_out.last closes each item.
// Configuration (route count, acked mask and timeout) is written through
// i_cfg_we, i_cfg_idx and i_cfg_data. The user must write it only while the
// block is idle; the block itself does not enforce this.
// One event is worked on at a time. Its handling walks the routes in use one
// per cycle through the route memory (registered read, then update and
// write back).
// Reset returns every route to idle and restores the configuration defaults.
// When the receiver stalls, the current result holds and no new input is
// taken until the last result of the item has been transferred.
module route_ack_tracker #(
    parameter int ROUTES = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rat_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  logic [rat_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  rat_pkg::t_in                i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output rat_pkg::t_out               o_out
);

    rat_pkg::t_ctl w_ctl;
    rat_pkg::t_sts w_sts;

    // Sequencing of accept, route walk and result delivery.
    rat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // Route memory, per-route update and result buffer.
    rat_dpath #(
        .ROUTES (ROUTES)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_ctl      (w_ctl),
        .o_sts      (w_sts),
        .o_out      (o_out)
    );

endmodule

/* design/rat_checker.sv */
module rat_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  rat_pkg::t_out i_out
);

    // Results are only offered while no new item can enter.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_in_stall)
        else $error("result offered while input is open");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out))
        else $error("stalled result changed");

    // Right after an input transfer, the input is closed.
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall |=> i_in_stall)
        else $error("input open right after a transfer");

    // After the final result of an item, no further result follows at once.
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_stall && i_out.last |=> !i_out_valid)
        else $error("result after the final one");

    // An empty result is always marked as the final one of its item.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out.sent |-> i_out.last)
        else $error("empty result not marked final");

endmodule

bind route_ack_tracker rat_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out       (o_out)
);
